// ===== rtl/bgr_quad_to_nv21_top_assert.svh =====
// Assertion macros for the BGR quad to NV21 converter.
// Expects a clock named clk and a reset named rst in the including scope.
`ifndef BGR_QUAD_TO_NV21_TOP_ASSERT_SVH
`define BGR_QUAD_TO_NV21_TOP_ASSERT_SVH

// same-cycle implication, checked at every edge out of reset
`define BQN_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bgr_quad_to_nv21: same-cycle check failed");

// next-cycle implication, checked at every edge out of reset
`define BQN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bgr_quad_to_nv21: next-cycle check failed");

`endif

// ===== rtl/bqn_pkg.sv =====
// Package for the BGR quad to NV21 converter: weights, widths, stage payloads.
// No dependencies.
`default_nettype none

package bqn_pkg;

  localparam int unsigned PIXELS = 4;

  localparam logic [15:0] LUMA_WR   = 16'd19595;
  localparam logic [15:0] LUMA_WG   = 16'd38470;
  localparam logic [15:0] LUMA_WB   = 16'd7471;
  localparam logic [23:0] LUMA_HALF = 24'd32768;

  localparam logic [15:0] CU_R = 16'd9634;
  localparam logic [15:0] CU_G = 16'd18940;
  localparam logic [15:0] CU_B = 16'd28574;
  localparam logic [15:0] CV_R = 16'd40305;
  localparam logic [15:0] CV_G = 16'd33751;
  localparam logic [15:0] CV_B = 16'd6554;

  localparam logic [27:0] CHROMA_OFFSET = 28'd33554432;

  typedef struct packed {
    logic [PIXELS-1:0][7:0] red;
    logic [PIXELS-1:0][7:0] green;
    logic [PIXELS-1:0][7:0] blue;
  } quad_t;

  typedef struct packed {
    logic [PIXELS-1:0][23:0] prod_r;
    logic [PIXELS-1:0][23:0] prod_g;
    logic [PIXELS-1:0][23:0] prod_b;
    logic [9:0]              sum_r;
    logic [9:0]              sum_g;
    logic [9:0]              sum_b;
  } stage1_t;

  typedef struct packed {
    logic [PIXELS-1:0][7:0] luma;
    logic [25:0]            cv_r;
    logic [25:0]            cv_g;
    logic [25:0]            cv_b;
    logic [25:0]            cu_r;
    logic [25:0]            cu_g;
    logic [25:0]            cu_b;
  } stage2_t;

  typedef struct packed {
    logic [7:0]             chroma_u;
    logic [7:0]             chroma_v;
    logic [PIXELS-1:0][7:0] luma;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/bqn_front.sv =====
// Stage 1: per-pixel luma products and four-pixel channel sums.
// Depends on bqn_pkg.
`default_nettype none

module bqn_front
  import bqn_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  quad_t   in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output stage1_t out_data
);

  stage1_t stage_next;

  always_comb begin
    stage_next = '0;
    for (int k = 0; k < PIXELS; k++) begin
      stage_next.prod_r[k] = 24'(in_data.red[k]) * 24'(LUMA_WR);
      stage_next.prod_g[k] = 24'(in_data.green[k]) * 24'(LUMA_WG);
      stage_next.prod_b[k] = 24'(in_data.blue[k]) * 24'(LUMA_WB);
    end
    stage_next.sum_r = 10'(in_data.red[0]) + 10'(in_data.red[1])
                     + 10'(in_data.red[2]) + 10'(in_data.red[3]);
    stage_next.sum_g = 10'(in_data.green[0]) + 10'(in_data.green[1])
                     + 10'(in_data.green[2]) + 10'(in_data.green[3]);
    stage_next.sum_b = 10'(in_data.blue[0]) + 10'(in_data.blue[1])
                     + 10'(in_data.blue[2]) + 10'(in_data.blue[3]);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= stage_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bqn_mix.sv =====
// Stage 2: luma sums with rounding, chroma weight products.
// Depends on bqn_pkg.
`default_nettype none

module bqn_mix
  import bqn_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  stage1_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output stage2_t out_data
);

  stage2_t     stage_next;
  logic [23:0] luma_acc [PIXELS];

  always_comb begin
    stage_next = '0;
    for (int k = 0; k < PIXELS; k++) begin
      luma_acc[k] = in_data.prod_r[k] + in_data.prod_g[k] + in_data.prod_b[k] + LUMA_HALF;
      stage_next.luma[k] = luma_acc[k][23:16];
    end
    stage_next.cv_r = 26'(in_data.sum_r) * 26'(CV_R);
    stage_next.cv_g = 26'(in_data.sum_g) * 26'(CV_G);
    stage_next.cv_b = 26'(in_data.sum_b) * 26'(CV_B);
    stage_next.cu_r = 26'(in_data.sum_r) * 26'(CU_R);
    stage_next.cu_g = 26'(in_data.sum_g) * 26'(CU_G);
    stage_next.cu_b = 26'(in_data.sum_b) * 26'(CU_B);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= stage_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bqn_clamp.sv =====
// Stage 3: chroma accumulation with offset, shift and clamp; output register.
// Depends on bqn_pkg.
`default_nettype none

module bqn_clamp
  import bqn_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  stage2_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  result_t     stage_next;
  logic [27:0] acc_v;
  logic [27:0] acc_u;

  function automatic logic [7:0] clamp_chroma(input logic [27:0] acc);
    logic [7:0] res;
    if (acc[27]) begin
      res = 8'd0;
    end else if (acc[26]) begin
      res = 8'd255;
    end else begin
      res = acc[25:18];
    end
    return res;
  endfunction

  always_comb begin
    acc_v = CHROMA_OFFSET + 28'(in_data.cv_r) - 28'(in_data.cv_g) - 28'(in_data.cv_b);
    acc_u = CHROMA_OFFSET + 28'(in_data.cu_b) - 28'(in_data.cu_r) - 28'(in_data.cu_g);
    stage_next.luma     = in_data.luma;
    stage_next.chroma_v = clamp_chroma(acc_v);
    stage_next.chroma_u = clamp_chroma(acc_u);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= stage_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bgr_quad_to_nv21_top.sv =====
// Top level of the BGR quad to NV21 converter: three-stage pipeline.
// Depends on bqn_pkg, bqn_front, bqn_mix, bqn_clamp, bgr_quad_to_nv21_top_assert.svh.
//
//   channel | role   | payload
//   s_*     | input  | one 2x2 BGR block, 96 bits
//   m_*     | output | four luma, V, U, 48 bits
//
// One block enters per cycle unless a stall on m_tready holds the pipe; each result is registered
// in the three register stages in turn: products, sums, chroma clamp.
// Each stage holds its item while the next one is full, so a stall on m_tready
// fills the pipe and then drops s_tready; nothing is lost or repeated.
// Reset clears the stage valid bits and holds s_tready low.
`default_nettype none

module bgr_quad_to_nv21_top
  import bqn_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // per pixel TL, TR, BL, BR from the low bits up: blue, green, red (8 bits each)
  input  logic [95:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right, chroma_v, chroma_u
  output logic [47:0] m_tdata
);

  quad_t   quad;
  stage1_t s1_data;
  stage2_t s2_data;
  result_t s3_data;
  logic    s1_ready;
  logic    s1_valid;
  logic    s2_valid;
  logic    s2_ready;
  logic    s3_ready;

  always_comb begin
    for (int k = 0; k < PIXELS; k++) begin
      quad.blue[k]  = s_tdata[24*k +: 8];
      quad.green[k] = s_tdata[24*k + 8 +: 8];
      quad.red[k]   = s_tdata[24*k + 16 +: 8];
    end
  end

  assign s_tready = s1_ready && !rst;

  bqn_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s1_ready),
    .in_data   (quad),
    .out_valid (s1_valid),
    .out_ready (s2_ready),
    .out_data  (s1_data)
  );

  bqn_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s2_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s3_ready),
    .out_data  (s2_data)
  );

  bqn_clamp u_clamp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_ready  (s3_ready),
    .in_data   (s2_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (s3_data)
  );

  assign m_tdata = s3_data;

`include "bgr_quad_to_nv21_top_assert.svh"

  `BQN_ASSERT_NOW(a_full_blocks_input, s1_valid && s2_valid && m_tvalid && !m_tready, !s_tready)
  `BQN_ASSERT_NEXT(a_s1_moves_to_s2, s1_valid && s2_ready, s2_valid)
  `BQN_ASSERT_NEXT(a_s2_moves_to_out, s2_valid && s3_ready, m_tvalid)

endmodule

`default_nettype wire

// ===== tb/bgr_quad_to_nv21_top_tb.sv =====
// Self-checking testbench for bgr_quad_to_nv21_top: 2x2 BGR blocks in, luma and NV21 chroma out.
// Directed table then random blocks under varying stream backpressure; each result is checked
// against a typed value or an in-bench fixed-point converter. Depends on bqn_pkg and the RTL.
module bgr_quad_to_nv21_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bqn_pkg::result_t;

  localparam longint Y_WR = 19595;
  localparam longint Y_WG = 38470;
  localparam longint Y_WB = 7471;
  localparam longint Y_ROUND = 32768;
  localparam longint U_WR = 9634;
  localparam longint U_WG = 18940;
  localparam longint U_WB = 28574;
  localparam longint V_WR = 40305;
  localparam longint V_WG = 33751;
  localparam longint V_WB = 6554;
  localparam longint UV_BIAS = 512 * 65536;
  localparam int UV_SHIFT = 18;

  localparam int RANDOM_PER_PHASE = 610;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 60;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } bgr_px_t;

  typedef bgr_px_t [3:0] bgr_quad_t;

  typedef struct packed {
    logic [95:0] quad;
    logic        typed;
    logic [47:0] want;
  } stim_row_t;

  localparam int NUM_DIRECTED = 20;
  localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
    {96'h000000_000000_000000_000000, 1'b1, 48'h8080_0000_0000},
    {96'hFFFFFF_FFFFFF_FFFFFF_FFFFFF, 1'b1, 48'h8080_FFFF_FFFF},
    {96'hFF0000_FF0000_FF0000_FF0000, 1'b1, 48'h5AFF_4C4C_4C4C},
    {96'h00FF00_00FF00_00FF00_00FF00, 1'b1, 48'h3600_9696_9696},
    {96'h0000FF_0000FF_0000FF_0000FF, 1'b1, 48'hEF66_1D1D_1D1D},
    {96'h000000_000000_000000_FFFFFF, 1'b0, 48'h0},
    {96'h000000_000000_FFFFFF_000000, 1'b0, 48'h0},
    {96'h000000_FFFFFF_000000_000000, 1'b0, 48'h0},
    {96'hFFFFFF_000000_000000_000000, 1'b0, 48'h0},
    {96'hFF00FF_FF00FF_FF00FF_FF00FF, 1'b0, 48'h0},
    {96'h00FFFF_00FFFF_00FFFF_00FFFF, 1'b0, 48'h0},
    {96'hFFFF00_FFFF00_FFFF00_FFFF00, 1'b0, 48'h0},
    {96'hAAAAAA_AAAAAA_AAAAAA_AAAAAA, 1'b0, 48'h0},
    {96'h555555_555555_555555_555555, 1'b0, 48'h0},
    {96'h123456_789ABC_DEF012_345678, 1'b0, 48'h0},
    {96'h010101_010101_010101_010101, 1'b0, 48'h0},
    {96'h808080_808080_808080_808080, 1'b0, 48'h0},
    {96'h7F7F7F_7F7F7F_7F7F7F_7F7F7F, 1'b0, 48'h0},
    {96'hFFFFFF_0000FF_00FF00_FF0000, 1'b0, 48'h0},
    {96'hFE0001_01FE01_0001FE_FEFE01, 1'b0, 48'h0}
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // per pixel TL, TR, BL, BR from the low bits up: blue, green, red
  logic [95:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // luma TL, TR, BL, BR, chroma_v, chroma_u from the low bits up
  logic [47:0] m_tdata;

  result_t nv21_expected [$];
  int      mismatch_count = 0;
  int      send_idle_pct = 10;
  int      recv_idle_pct = 60;
  bit      hold_start = 1'b0;
  bit      hold_done = 1'b0;
  int      hold_left = 0;
  int      quiet_cycles = 0;
  string   field_names [6] = '{"luma_top_left", "luma_top_right", "luma_bottom_left",
                               "luma_bottom_right", "chroma_v", "chroma_u"};

  bgr_quad_to_nv21_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [7:0] clamp_chroma(longint acc);
    longint q;
    if (acc < 0) return 8'd0;
    q = acc >>> UV_SHIFT;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic result_t nv21_of_quad(bgr_quad_t q);
    result_t res;
    longint  sum_r, sum_g, sum_b, acc;
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    for (int k = 0; k < 4; k++) begin
      acc = Y_WR * longint'(q[k].red) + Y_WG * longint'(q[k].green)
          + Y_WB * longint'(q[k].blue) + Y_ROUND;
      res.luma[k] = acc[23:16];
      sum_r += longint'(q[k].red);
      sum_g += longint'(q[k].green);
      sum_b += longint'(q[k].blue);
    end
    res.chroma_v = clamp_chroma(V_WR * sum_r - V_WG * sum_g - V_WB * sum_b + UV_BIAS);
    res.chroma_u = clamp_chroma(U_WB * sum_b - U_WR * sum_r - U_WG * sum_g + UV_BIAS);
    return res;
  endfunction

  function automatic bgr_quad_t random_quad();
    bgr_quad_t q;
    int        kind, lead, gray;
    kind = $urandom_range(9);
    lead = $urandom_range(2);
    for (int k = 0; k < 4; k++) begin
      case (kind)
        5, 6: begin
          q[k].red   = {8{1'($urandom_range(1))}};
          q[k].green = {8{1'($urandom_range(1))}};
          q[k].blue  = {8{1'($urandom_range(1))}};
        end
        7: begin
          gray = $urandom_range(255);
          q[k] = {3{8'(gray)}};
        end
        8: begin
          q[k].red   = 8'((lead == 0) ? $urandom_range(255, 200) : $urandom_range(40));
          q[k].green = 8'((lead == 1) ? $urandom_range(255, 200) : $urandom_range(40));
          q[k].blue  = 8'((lead == 2) ? $urandom_range(255, 200) : $urandom_range(40));
        end
        9: begin
          q[k].red   = 8'($urandom_range(1) ? $urandom_range(255, 252) : $urandom_range(3));
          q[k].green = 8'($urandom_range(1) ? $urandom_range(255, 252) : $urandom_range(3));
          q[k].blue  = 8'($urandom_range(1) ? $urandom_range(255, 252) : $urandom_range(3));
        end
        default: begin
          q[k].red   = 8'($urandom_range(255));
          q[k].green = 8'($urandom_range(255));
          q[k].blue  = 8'($urandom_range(255));
        end
      endcase
    end
    return q;
  endfunction

  task automatic offer_quad(input bgr_quad_t q, input result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= q;
    do @(posedge clk); while (!s_tready);
    nv21_expected.push_back(want);
  endtask

  initial begin : stimulus
    bgr_quad_t q;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      offer_quad(DIRECTED[i].quad,
                 DIRECTED[i].typed ? result_t'(DIRECTED[i].want)
                                   : nv21_of_quad(DIRECTED[i].quad));
    end
    hold_start = 1'b1;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 60 : 0;
      recv_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 10 : 0;
      repeat (RANDOM_PER_PHASE) begin
        q = random_quad();
        offer_quad(q, nv21_of_quad(q));
      end
    end
    s_tvalid <= 1'b0;
    while (nv21_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && nv21_expected.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hold off once for a long stretch so the pipe fills and s_tready drops
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_start && !hold_done) begin
      m_tready  <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    result_t want, got;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (nv21_expected.size() == 0) begin
        if (mismatch_count < REPORT_MAX)
          $display("%0t: result with nothing expected: %h", $realtime, got);
        mismatch_count++;
      end else begin
        want = nv21_expected.pop_front();
        for (int f = 0; f < 6; f++) begin
          if (got[8*f +: 8] !== want[8*f +: 8]) begin
            if (mismatch_count < REPORT_MAX)
              $display("%0t: %s expected %0d, got %0d", $realtime, field_names[f],
                       want[8*f +: 8], got[8*f +: 8]);
            mismatch_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
